/* rtl/gulsc_pkg.sv */
// gulsc_pkg: shared types, constants and leap-second threshold table
// for the GPS/UTC leap-second converter. No dependencies.
package gulsc_pkg;

    localparam int NUM_LEAPS = 18;
    localparam int LEAP_TABLE_LEN = 18;
    localparam int LEAP_USED = (NUM_LEAPS > LEAP_TABLE_LEN) ? LEAP_TABLE_LEN : NUM_LEAPS;
    localparam int LEAP_CNT_W = 5;
    localparam int TIME_IN_W = 33;
    localparam int TIME_OUT_W = 35;
    localparam int OFFSET_W = 32;
    localparam int OPND_W = TIME_IN_W + 1;
    localparam logic [OFFSET_W-1:0] EPOCH_OFFSET_RST = 32'd315964800;

    localparam logic MODE_UTC2GPS = 1'b0;
    localparam logic MODE_GPS2UTC = 1'b1;

    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [TIME_OUT_W-1:0] tout_t;

    typedef struct packed {
        logic  mode;
        opnd_t opnd;
        tout_t base;
    } prep_t;

    // Leap threshold in GPS seconds; UTC->GPS uses threshold minus index.
    function automatic opnd_t leap_thr(input logic [LEAP_CNT_W-1:0] idx, input logic mode);
        opnd_t t;
        begin
            case (idx)
                5'd0:    t = 34'sd46828800;
                5'd1:    t = 34'sd78364801;
                5'd2:    t = 34'sd109900802;
                5'd3:    t = 34'sd173059203;
                5'd4:    t = 34'sd252028804;
                5'd5:    t = 34'sd315187205;
                5'd6:    t = 34'sd346723206;
                5'd7:    t = 34'sd393984007;
                5'd8:    t = 34'sd425520008;
                5'd9:    t = 34'sd457056009;
                5'd10:   t = 34'sd504489610;
                5'd11:   t = 34'sd551750411;
                5'd12:   t = 34'sd599184012;
                5'd13:   t = 34'sd820108813;
                5'd14:   t = 34'sd914803214;
                5'd15:   t = 34'sd1025136015;
                5'd16:   t = 34'sd1119744016;
                5'd17:   t = 34'sd1167264017;
                default: t = '0;
            endcase
            if (mode == MODE_UTC2GPS)
            begin
                t = t - $signed({{(OPND_W-LEAP_CNT_W){1'b0}}, idx});
            end
            return t;
        end
    endfunction

endpackage

/* rtl/gulsc_prep.sv */
// gulsc_prep: forms the compare operand and the base time for one request.
// Depends on gulsc_pkg.
module gulsc_prep import gulsc_pkg::*;
(
    input  logic                  mode,
    input  logic [TIME_IN_W-1:0]  time_in,
    input  logic [OFFSET_W-1:0]   epoch_offset,
    output prep_t                 prep
);

    opnd_t g;
    tout_t sum;

    assign g   = $signed({1'b0, time_in}) - $signed({2'b00, epoch_offset});
    assign sum = $signed({2'b00, time_in}) + $signed({3'b000, epoch_offset});

    always_comb
    begin
        prep.mode = mode;
        if (mode == MODE_GPS2UTC)
        begin
            prep.opnd = $signed({1'b0, time_in});
            prep.base = sum;
        end
        else
        begin
            prep.opnd = g;
            prep.base = {g[OPND_W-1], g};
        end
    end

endmodule

/* rtl/gulsc_leap_cnt.sv */
// gulsc_leap_cnt: parallel threshold compares and count of passed leaps.
// Depends on gulsc_pkg.
module gulsc_leap_cnt import gulsc_pkg::*;
(
    input  logic                   mode,
    input  opnd_t                  opnd,
    output logic [LEAP_CNT_W-1:0]  count
);

    always_comb
    begin
        logic [LEAP_CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < LEAP_USED; i++)
        begin
            if (opnd >= leap_thr(LEAP_CNT_W'(i), mode))
            begin
                acc = acc + LEAP_CNT_W'(1);
            end
        end
        count = acc;
    end

endmodule

/* rtl/gps_utc_leap_second_converter.sv */
// Converts whole-second time stamps between Unix UTC and GPS time. A request
// passes three register stages (operand, leap count, result), and one request
// is taken every cycle unless back-pressure from out_ready fills the stages;
// each stage holds its request only while the stage after it is full.
// Depends on gulsc_pkg, gulsc_prep, gulsc_leap_cnt.
module gps_utc_leap_second_converter import gulsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [OFFSET_W-1:0]    cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [TIME_IN_W-1:0]   time_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [TIME_OUT_W-1:0] time_out,
    output logic [LEAP_CNT_W-1:0]  leap_count
);

    logic [OFFSET_W-1:0]   epoch_offset_reg;
    prep_t                 prep_next;
    prep_t                 s1_reg;
    logic                  s1_valid_reg;
    logic [LEAP_CNT_W-1:0] cnt_next;
    logic [LEAP_CNT_W-1:0] s2_cnt_reg;
    logic                  s2_mode_reg;
    tout_t                 s2_base_reg;
    logic                  s2_valid_reg;
    tout_t                 time_out_next;
    tout_t                 time_out_reg;
    logic [LEAP_CNT_W-1:0] leap_count_reg;
    logic                  out_valid_reg;
    logic                  out_load;
    logic                  s2_load;
    logic                  s1_load;
    tout_t                 cnt_ext;

    gulsc_prep u_prep
    (
        .mode         (mode),
        .time_in      (time_in),
        .epoch_offset (epoch_offset_reg),
        .prep         (prep_next)
    );

    gulsc_leap_cnt u_leap_cnt
    (
        .mode  (s1_reg.mode),
        .opnd  (s1_reg.opnd),
        .count (cnt_next)
    );

    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_load);
    assign s1_load  = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || s2_load;

    assign cnt_ext = $signed({{(TIME_OUT_W-LEAP_CNT_W){1'b0}}, s2_cnt_reg});
    assign time_out_next = (s2_mode_reg == MODE_GPS2UTC) ? (s2_base_reg - cnt_ext)
                                                         : (s2_base_reg + cnt_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_offset_reg <= EPOCH_OFFSET_RST;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                epoch_offset_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_valid_reg || out_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_reg <= prep_next;
        end
        if (s2_load)
        begin
            s2_cnt_reg  <= cnt_next;
            s2_mode_reg <= s1_reg.mode;
            s2_base_reg <= s1_reg.base;
        end
        if (out_load)
        begin
            time_out_reg   <= time_out_next;
            leap_count_reg <= s2_cnt_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign time_out   = time_out_reg;
    assign leap_count = leap_count_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (leap_count <= LEAP_CNT_W'(LEAP_USED)))
        else $error("leap count above table size");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted request lost at first stage");

    a_pre_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && s1_reg.opnd[OPND_W-1]) |=> (s2_cnt_reg == '0))
        else $error("leap counted before GPS epoch");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for gps_utc_leap_second_converter: random and directed
// conversions in both directions, predicted in-bench and checked in order.
// Depends on gulsc_pkg and the converter RTL.
`timescale 1ns / 100ps

module testbench;
    import gulsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 110;
    localparam int LEAP_ENTRIES = LEAP_USED;
    localparam longint TIME_IN_MAX = 64'h1_FFFF_FFFF;

    typedef struct packed {
        logic signed [TIME_OUT_W-1:0] conv;
        logic [LEAP_CNT_W-1:0]        leaps;
    } conv_res_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [OFFSET_W-1:0]           cfg_wdata;
    logic                          in_valid;
    logic                          in_ready;
    logic                          mode;
    logic [TIME_IN_W-1:0]          time_in;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [TIME_OUT_W-1:0]  time_out;
    logic [LEAP_CNT_W-1:0]         leap_count;

    conv_res_t           pending_conv[$];
    logic [OFFSET_W-1:0] epoch_model = EPOCH_OFFSET_RST;
    int                  errors = 0;
    int                  idle_cycles = 0;
    int                  burst_left = 0;
    bit                  tx_dense = 1'b0;
    bit                  hold_req = 1'b0;
    bit                  hold_active = 1'b0;
    int                  hold_len = 0;

    gps_utc_leap_second_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .time_in    (time_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .time_out   (time_out),
        .leap_count (leap_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // leap thresholds in GPS seconds
    function automatic longint gps_leap_thr(input int i);
        case (i)
            0:       gps_leap_thr = 46828800;
            1:       gps_leap_thr = 78364801;
            2:       gps_leap_thr = 109900802;
            3:       gps_leap_thr = 173059203;
            4:       gps_leap_thr = 252028804;
            5:       gps_leap_thr = 315187205;
            6:       gps_leap_thr = 346723206;
            7:       gps_leap_thr = 393984007;
            8:       gps_leap_thr = 425520008;
            9:       gps_leap_thr = 457056009;
            10:      gps_leap_thr = 504489610;
            11:      gps_leap_thr = 551750411;
            12:      gps_leap_thr = 599184012;
            13:      gps_leap_thr = 820108813;
            14:      gps_leap_thr = 914803214;
            15:      gps_leap_thr = 1025136015;
            16:      gps_leap_thr = 1119744016;
            default: gps_leap_thr = 1167264017;
        endcase
    endfunction

    function automatic conv_res_t convert_stamp(input logic m, input logic [TIME_IN_W-1:0] t,
                                                input logic [OFFSET_W-1:0] off);
        conv_res_t r;
        longint    ts;
        longint    os;
        longint    acc;
        int        n;
        ts = $signed({31'b0, t});
        os = $signed({32'b0, off});
        n = 0;
        if (m == MODE_UTC2GPS)
        begin
            acc = ts - os;
            for (int i = 0; i < LEAP_ENTRIES; i++)
            begin
                if (acc >= gps_leap_thr(i) - i)
                    n++;
            end
            acc = acc + n;
        end
        else
        begin
            for (int i = 0; i < LEAP_ENTRIES; i++)
            begin
                if (ts >= gps_leap_thr(i))
                    n++;
            end
            acc = ts + os - n;
        end
        r.conv = acc[TIME_OUT_W-1:0];
        r.leaps = n[LEAP_CNT_W-1:0];
        return r;
    endfunction

    function automatic logic [TIME_IN_W-1:0] clamp_stamp(input longint v);
        if (v < 0)
            return '0;
        if (v > TIME_IN_MAX)
            return TIME_IN_MAX[TIME_IN_W-1:0];
        return v[TIME_IN_W-1:0];
    endfunction

    // mostly near leap boundaries in the active direction, some full-range noise
    function automatic logic [TIME_IN_W-1:0] pick_stamp(input logic m,
                                                        input logic [OFFSET_W-1:0] off);
        longint base;
        int     i;
        int     sel;
        sel = $urandom_range(0, 9);
        i = $urandom_range(0, LEAP_ENTRIES - 1);
        if (sel < 6)
        begin
            base = (m == MODE_UTC2GPS) ? longint'(off) + gps_leap_thr(i) - i : gps_leap_thr(i);
            return clamp_stamp(base + $urandom_range(0, 32) - 16);
        end
        else if (sel < 8)
            return {1'($urandom_range(0, 1)), $urandom};
        else
        begin
            base = (m == MODE_UTC2GPS) ? longint'(off) : 0;
            return clamp_stamp(base + $urandom_range(0, 1400000000) - 1000);
        end
    endfunction

    task automatic send_req(input logic m, input logic [TIME_IN_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        mode <= m;
        time_in <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            gap = tx_dense ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_conv.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    task automatic test_directed();
        longint off;
        off = longint'(EPOCH_OFFSET_RST);
        send_req(MODE_UTC2GPS, '0);
        send_req(MODE_UTC2GPS, TIME_IN_MAX[TIME_IN_W-1:0]);
        send_req(MODE_UTC2GPS, clamp_stamp(off - 1));
        send_req(MODE_UTC2GPS, clamp_stamp(off));
        send_req(MODE_UTC2GPS, clamp_stamp(off + gps_leap_thr(0) - 1));
        send_req(MODE_UTC2GPS, clamp_stamp(off + gps_leap_thr(0)));
        send_req(MODE_UTC2GPS, clamp_stamp(off + gps_leap_thr(17) - 18));
        send_req(MODE_UTC2GPS, clamp_stamp(off + gps_leap_thr(17) - 17));
        send_req(MODE_GPS2UTC, '0);
        send_req(MODE_GPS2UTC, TIME_IN_MAX[TIME_IN_W-1:0]);
        send_req(MODE_GPS2UTC, clamp_stamp(gps_leap_thr(0) - 1));
        send_req(MODE_GPS2UTC, clamp_stamp(gps_leap_thr(0)));
        send_req(MODE_GPS2UTC, clamp_stamp(gps_leap_thr(8)));
        send_req(MODE_GPS2UTC, clamp_stamp(gps_leap_thr(17) - 1));
        send_req(MODE_GPS2UTC, clamp_stamp(gps_leap_thr(17)));
        send_req(MODE_UTC2GPS, 33'h0_AAAA_AAAA);
        send_req(MODE_UTC2GPS, 33'h1_5555_5555);
        send_req(MODE_GPS2UTC, 33'h0_AAAA_AAAA);
        send_req(MODE_GPS2UTC, 33'h1_5555_5555);
        drain();
    endtask

    task automatic test_offset_extremes();
        write_offset('0);
        send_req(MODE_UTC2GPS, '0);
        send_req(MODE_UTC2GPS, clamp_stamp(gps_leap_thr(5) - 5));
        send_req(MODE_UTC2GPS, TIME_IN_MAX[TIME_IN_W-1:0]);
        send_req(MODE_GPS2UTC, TIME_IN_MAX[TIME_IN_W-1:0]);
        drain();
        write_offset('1);
        send_req(MODE_UTC2GPS, '0);
        send_req(MODE_UTC2GPS, TIME_IN_MAX[TIME_IN_W-1:0]);
        send_req(MODE_UTC2GPS, clamp_stamp(64'hFFFF_FFFF + gps_leap_thr(17) - 17));
        send_req(MODE_GPS2UTC, '0);
        send_req(MODE_GPS2UTC, TIME_IN_MAX[TIME_IN_W-1:0]);
        drain();
    endtask

    task automatic test_random_phase(input logic [OFFSET_W-1:0] off);
        logic m;
        write_offset(off);
        tx_dense = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            m = 1'($urandom_range(0, 1));
            send_req(m, pick_stamp(m, off));
        end
        drain();
        tx_dense = 1'b0;
    endtask

    task automatic test_backpressure();
        logic m;
        hold_len = 300;
        hold_req = 1'b1;
        while (!hold_active)
            @(posedge clk);
        tx_dense = 1'b1;
        for (int k = 0; k < 48; k++)
        begin
            m = 1'($urandom_range(0, 1));
            send_req(m, pick_stamp(m, epoch_model));
        end
        tx_dense = 1'b0;
        drain();
    endtask

    initial
    begin : rx_pace
        int   run;
        logic lvl;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_req = 1'b0;
                hold_active = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lvl = 1'b1;
                        run = $urandom_range(10, 40);
                    end
                    1:
                    begin
                        lvl = 1'b0;
                        run = $urandom_range(1, 8);
                    end
                    default:
                    begin
                        lvl = 1'($urandom_range(0, 1));
                        run = $urandom_range(1, 3);
                    end
                endcase
                out_ready <= lvl;
                repeat (run) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : scoreboard
        conv_res_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (in_valid && in_ready)
                pending_conv.push_back(convert_stamp(mode, time_in, epoch_model));
            if (out_valid && out_ready)
            begin
                if (pending_conv.size() == 0)
                begin
                    $display("%0t: unexpected result time_out %0d leap_count %0d",
                             $time, time_out, leap_count);
                    errors++;
                end
                else
                begin
                    want = pending_conv.pop_front();
                    if (time_out !== want.conv)
                    begin
                        $display("%0t: time_out mismatch exp %0d got %0d",
                                 $time, want.conv, time_out);
                        errors++;
                    end
                    if (leap_count !== want.leaps)
                    begin
                        $display("%0t: leap_count mismatch exp %0d got %0d",
                                 $time, want.leaps, leap_count);
                        errors++;
                    end
                end
            end
            if (cfg_we)
                epoch_model = cfg_wdata;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        mode <= MODE_UTC2GPS;
        time_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_offset_extremes();
        test_random_phase(EPOCH_OFFSET_RST);
        test_random_phase('0);
        test_random_phase('1);
        test_backpressure();
        test_random_phase($urandom);
        test_random_phase($urandom);
        test_random_phase(EPOCH_OFFSET_RST);
        drain();

        if (errors == 0 && pending_conv.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/gulsc_pkg.sv
rtl/gulsc_prep.sv
rtl/gulsc_leap_cnt.sv
rtl/gps_utc_leap_second_converter.sv
tb/testbench.sv
